/* rtl/ansi_escape_stripper_macros.svh */
// Assertion helpers included by the stripper module.
`ifndef ANSI_ESCAPE_STRIPPER_MACROS_SVH
`define ANSI_ESCAPE_STRIPPER_MACROS_SVH

// Property checked outside reset.
`define AES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define AES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/aes_pkg.sv */
package aes_pkg;

  localparam int CountWidthDefault = 16;
  localparam int VisW = 16;

  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_CSI_OPEN = 8'h5B;
  localparam logic [7:0] BYTE_OSC_OPEN = 8'h5D;
  localparam logic [7:0] BYTE_ST_TAIL = 8'h5C;
  localparam logic [7:0] BYTE_FE_LOW = 8'h40;
  localparam logic [7:0] BYTE_FE_HIGH = 8'h5F;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_CSI     = 3'd2,
    MODE_OSC     = 3'd3,
    MODE_OSC_ESC = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_word_t;

  typedef struct packed {
    logic            keep;
    logic [7:0]      byte_out;
    logic [VisW-1:0] visible_count;
    logic            final_out;
  } result_word_t;

  // Parser state excluding the code point counter.
  typedef struct packed {
    mode_t      mode;
    logic [1:0] cont_left;
  } parse_state_t;

  // What one byte does to the parser.
  typedef struct packed {
    logic         keep;
    logic         count_en;
    parse_state_t state_next;
  } step_res_t;

endpackage

/* rtl/ansi_escape_stripper.sv */
// A word accepted into the input register moves on to the result register.
// Throughput: one word per cycle while the result is not stalled; the parser state is updated in the same cycle.
// The input register and the result register let a new word in while a result waits.
// Reset (rst, synchronous, active high) empties both registers and returns the parser
// to normal text with a zero count; a word marked end_of_text resets the parser and count after it.
module ansi_escape_stripper
  import aes_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         text_valid,
  output logic         text_stall,
  input  text_word_t   text_word,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result_word
);

  localparam int ExtW = (COUNT_WIDTH > VisW) ? COUNT_WIDTH : VisW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // Input register: holds one accepted word until the parser takes it.
  logic       stage_valid;
  text_word_t stage;

  // Parser state and the running code point count.
  parse_state_t           state;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [ExtW-1:0]        count_ext;

  step_res_t step;
  logic      advance;
  logic      text_take;

  // The staged word moves on when the result register is empty or being emptied.
  assign advance    = stage_valid && (!result_valid || !result_stall);
  assign text_stall = stage_valid && !advance;
  assign text_take  = text_valid && !text_stall;

  aes_step u_step (
    .text_byte (stage.text_byte),
    .state     (state),
    .res       (step)
  );

  // The counter saturates at its all-ones value.
  always_comb begin
    count_next = count;
    if (step.count_en && count != CountMax) begin
      count_next = count + COUNT_WIDTH'(1);
    end
  end

  // The result carries the low bits of the count, zero filled for narrow counters.
  assign count_ext = ExtW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      stage <= text_word;
    end
  end

  // Parser state advances once per word; the final word of a string clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode      <= MODE_TEXT;
      state.cont_left <= 2'd0;
      count           <= '0;
    end else if (advance) begin
      if (stage.end_of_text) begin
        state.mode      <= MODE_TEXT;
        state.cont_left <= 2'd0;
        count           <= '0;
      end else begin
        state <= step.state_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word.keep          <= step.keep;
      result_word.byte_out      <= stage.text_byte;
      result_word.visible_count <= count_ext[VisW-1:0];
      result_word.final_out     <= stage.end_of_text;
    end
  end

`include "ansi_escape_stripper_macros.svh"

  // Continuation bytes are only pending while in normal text.
  `AES_ASSERT(a_cont_in_text, (state.mode != MODE_TEXT) |-> (state.cont_left == 2'd0), "continuation pending outside text")
  // A final word leaves the parser in its reset state.
  `AES_ASSERT(a_final_clears, (advance && stage.end_of_text) |=> (state.mode == MODE_TEXT && state.cont_left == 2'd0 && count == '0), "state not cleared after final word")
  // Within a string the count never goes down.
  `AES_ASSERT(a_count_rises, (advance && !stage.end_of_text) |=> (count >= $past(count)), "count decreased")
  // An empty result register never holds back the input.
  `AES_ASSERT_ALWAYS(a_no_idle_stall, (!result_valid) |-> (!text_stall), "input stalled with empty output")

endmodule

/* rtl/aes_step.sv */
module aes_step
  import aes_pkg::*;
(
  input  logic [7:0]   text_byte,
  input  parse_state_t state,
  output step_res_t    res
);

  // Normal-text handling of one byte, with the current continuation count.
  function automatic step_res_t text_step(input logic [7:0] b, input logic [1:0] cont);
    step_res_t r;
    r = '0;
    r.state_next.mode = MODE_TEXT;
    if (cont != 2'd0) begin
      r.keep = 1'b1;
      r.state_next.cont_left = cont - 2'd1;
    end else if (b == BYTE_ESC) begin
      r.state_next.mode = MODE_ESC;
    end else begin
      r.keep = 1'b1;
      r.count_en = 1'b1;
      if (b[7:5] == 3'b110) begin
        r.state_next.cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        r.state_next.cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        r.state_next.cont_left = 2'd3;
      end
    end
    return r;
  endfunction

  // Inside an OSC string: BEL ends it, ESC may start the string terminator.
  function automatic mode_t osc_mode(input logic [7:0] b);
    mode_t m;
    m = MODE_OSC;
    if (b == BYTE_BEL) begin
      m = MODE_TEXT;
    end else if (b == BYTE_ESC) begin
      m = MODE_OSC_ESC;
    end
    return m;
  endfunction

  always_comb begin
    res = '0;
    res.state_next.mode = state.mode;
    unique case (state.mode)
      MODE_ESC: begin
        if (text_byte == BYTE_CSI_OPEN) begin
          res.state_next.mode = MODE_CSI;
        end else if (text_byte == BYTE_OSC_OPEN) begin
          res.state_next.mode = MODE_OSC;
        end else if (text_byte >= BYTE_FE_LOW && text_byte <= BYTE_FE_HIGH) begin
          res.state_next.mode = MODE_TEXT;
        end else begin
          res = text_step(text_byte, state.cont_left);
        end
      end
      MODE_CSI: begin
        if (text_byte >= BYTE_FE_LOW) begin
          res.state_next.mode = MODE_TEXT;
        end
      end
      MODE_OSC: begin
        res.state_next.mode = osc_mode(text_byte);
      end
      MODE_OSC_ESC: begin
        if (text_byte == BYTE_ST_TAIL) begin
          res.state_next.mode = MODE_TEXT;
        end else begin
          res.state_next.mode = osc_mode(text_byte);
        end
      end
      default: begin
        res = text_step(text_byte, state.cont_left);
      end
    endcase
  end

endmodule
